// ===== rtl/ldfd_pkg.sv =====
// shared types, codes and constants of the length-prefixed frame deframer
`default_nettype none

package ldfd_pkg;

    // header layout
    localparam int HDR_LEN   = 12;
    localparam int HDR_IDX_W = 4;
    localparam int LEN_W     = 21;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // default payload cap
    localparam logic [31:0] MAX_PAYLOAD_DEF = 32'd1048576;

    // register reset values
    localparam logic [31:0] MAGIC_RST   = 32'd0;
    localparam logic [15:0] VERSION_RST = 16'd1;

    // input command codes
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

    // result status codes
    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_END     = 3'd2,
        ST_MAGIC   = 3'd3,
        ST_VERSION = 3'd4,
        ST_FLAGS   = 3'd5,
        ST_LONG    = 3'd6,
        ST_TRUNC   = 3'd7
    } t_status;

    // one result transaction
    typedef struct packed {
        t_status     status;
        logic [7:0]  payload_byte;
        logic        last;
    } t_result;

    // keep the low length bits and saturate at the cap
    function automatic logic [LEN_W-1:0] cap_payload(input logic [31:0] v,
                                                      input logic [31:0] lim);
        logic [LEN_W-1:0] low;
        low = v[LEN_W-1:0];
        if ({{(32-LEN_W){1'b0}}, low} > lim) begin
            return lim[LEN_W-1:0];
        end
        return low;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ldfd_core.sv =====
// header collection, header checks, payload counting and config registers
`default_nettype none

module ldfd_core
    import ldfd_pkg::*;
#(
    parameter logic [31:0] MAX_PAYLOAD_BYTES = MAX_PAYLOAD_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_fire,
    input  wire logic                 i_cmd,
    input  wire logic [7:0]           i_data_byte,
    output logic                      o_res_valid,
    output t_result                   o_res
);

    localparam logic [LEN_W-1:0] MAX_RST = cap_payload(MAX_PAYLOAD_BYTES, MAX_PAYLOAD_BYTES);
    localparam logic [HDR_IDX_W-1:0] LAST_IDX = HDR_IDX_W'(HDR_LEN - 1);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } t_phase;

    // configuration registers
    logic [31:0]      r_magic;
    logic [15:0]      r_version;
    logic [LEN_W-1:0] r_max_len;

    // deframer state
    t_phase               r_phase, n_phase;
    logic [HDR_IDX_W-1:0] r_count, n_count;
    logic [LEN_W-1:0]     r_remain, n_remain;
    logic [7:0]           r_hdr [HDR_LEN-1];

    logic [HDR_IDX_W-1:0] hdr_idx;
    logic [31:0]          hdr_magic;
    logic [15:0]          hdr_version;
    logic [15:0]          hdr_flags;
    logic [31:0]          hdr_len;
    logic                 hdr_store_we;

    // header fields; the final length byte comes straight from the input
    assign hdr_magic   = {r_hdr[0], r_hdr[1], r_hdr[2], r_hdr[3]};
    assign hdr_version = {r_hdr[4], r_hdr[5]};
    assign hdr_flags   = {r_hdr[6], r_hdr[7]};
    assign hdr_len     = {r_hdr[8], r_hdr[9], r_hdr[10], i_data_byte};
    assign hdr_idx     = (r_count > LAST_IDX) ? '0 : r_count;

    // next state and result for the transaction in the input register
    always_comb begin
        n_phase             = r_phase;
        n_count             = r_count;
        n_remain            = r_remain;
        hdr_store_we        = 1'b0;
        o_res_valid         = 1'b0;
        o_res.status        = ST_DATA;
        o_res.payload_byte  = '0;
        o_res.last          = 1'b0;
        if (i_cmd == CMD_CLOSE) begin
            n_phase  = PH_HEADER;
            n_count  = '0;
            n_remain = '0;
            case (r_phase)
                PH_HEADER: begin
                    o_res_valid  = 1'b1;
                    o_res.status = (r_count == '0) ? ST_END : ST_TRUNC;
                end
                PH_PAYLOAD: begin
                    o_res_valid  = 1'b1;
                    o_res.status = ST_TRUNC;
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    if (hdr_idx != LAST_IDX) begin
                        hdr_store_we = 1'b1;
                        n_count      = hdr_idx + 1'b1;
                    end else begin
                        n_count     = '0;
                        o_res_valid = 1'b1;
                        if (hdr_magic != r_magic) begin
                            n_phase      = PH_DROP;
                            o_res.status = ST_MAGIC;
                        end else if (hdr_version != r_version) begin
                            n_phase      = PH_DROP;
                            o_res.status = ST_VERSION;
                        end else if (hdr_flags != '0) begin
                            n_phase      = PH_DROP;
                            o_res.status = ST_FLAGS;
                        end else if (hdr_len > {{(32-LEN_W){1'b0}}, r_max_len}) begin
                            n_phase      = PH_DROP;
                            o_res.status = ST_LONG;
                        end else if (hdr_len == '0) begin
                            o_res.status = ST_EMPTY;
                        end else begin
                            o_res_valid = 1'b0;
                            n_remain    = hdr_len[LEN_W-1:0];
                            n_phase     = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    o_res_valid        = 1'b1;
                    o_res.status       = ST_DATA;
                    o_res.payload_byte = i_data_byte;
                    if (r_remain <= LEN_W'(1)) begin
                        o_res.last = 1'b1;
                        n_remain   = '0;
                        n_phase    = PH_HEADER;
                        n_count    = '0;
                    end else begin
                        n_remain = r_remain - 1'b1;
                    end
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_count  <= '0;
            r_remain <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_remain <= n_remain;
        end
    end

    // header byte store
    always_ff @(posedge i_clk) begin
        if (i_fire && hdr_store_we) begin
            r_hdr[hdr_idx] <= i_data_byte;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= MAGIC_RST;
            r_version <= VERSION_RST;
            r_max_len <= MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAGIC:   r_magic   <= i_cfg_data;
                CFG_VERSION: r_version <= i_cfg_data[15:0];
                CFG_MAX_LEN: r_max_len <= cap_payload(i_cfg_data, MAX_PAYLOAD_BYTES);
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ldfd_out_stage.sv =====
// result register with valid and stall towards the receiver
`default_nettype none

module ldfd_out_stage
    import ldfd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire t_result  i_res,
    output logic          o_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_status       o_status,
    output logic [7:0]    o_payload_byte,
    output logic          o_last
);

    logic    r_valid;
    t_result r_res;

    // the register takes a new result when empty or when its content leaves
    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_status       = r_res.status;
    assign o_payload_byte = r_res.payload_byte;
    assign o_last         = r_res.last;

endmodule

`default_nettype wire

// ===== rtl/length_prefixed_frame_deframer_unit.sv =====
// top level of the length-prefixed frame deframer
//
// Input channel: one transaction per received byte (i_cmd data) or per stream
// close (i_cmd close), on i_in_valid / o_in_stall. Output channel: status,
// payload byte and last flag on o_out_valid / i_out_stall. A transaction is
// moved at a clock edge with valid high and stall low.
// The block takes one transaction per cycle while the receiver does not stall.
// A transaction is judged in the input register against the header state; its
// result, if any, is loaded into the result register and leaves from there.
// The first eleven header bytes and bytes dropped after an error give no result.
// The twelfth header byte is checked in the same cycle it is processed.
// Configuration (magic, version, payload cap) is written through i_cfg_we,
// i_cfg_index, i_cfg_data; the user must write it only while no transaction is
// in flight, and the block itself does not enforce this.
// Synchronous reset (i_rst_n low) empties both registers, returns the block
// to header collection and restores the register defaults.
// While the receiver stalls with a result waiting, processing halts and
// o_in_stall rises once the input register is full; nothing is lost.
`default_nettype none

module length_prefixed_frame_deframer_unit
    import ldfd_pkg::*;
#(
    parameter logic [31:0] MAX_PAYLOAD_BYTES = MAX_PAYLOAD_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_cmd,
    input  wire logic [7:0]           i_data_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [2:0]                o_status,
    output logic [7:0]                o_payload_byte,
    output logic                      o_last
);

    logic       r_in_valid;
    logic       r_cmd;
    logic [7:0] r_data_byte;
    logic       out_ready;
    logic       fire;
    logic       in_accept;
    logic       res_valid;
    t_result    res;
    t_status    out_status;

    // input register advances when the result register can take its outcome
    assign fire       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd       <= i_cmd;
            r_data_byte <= i_data_byte;
        end
    end

    // header checks and payload tracking
    ldfd_core #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_cmd       (r_cmd),
        .i_data_byte (r_data_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    ldfd_out_stage u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (fire && res_valid),
        .i_res          (res),
        .o_ready        (out_ready),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (out_status),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last)
    );

    assign o_status = out_status;

endmodule

`default_nettype wire

// ===== tb/sv/length_prefixed_frame_deframer_unit_tb.sv =====
// self-checking testbench for the length-prefixed frame deframer unit
`timescale 1ns / 100ps

module length_prefixed_frame_deframer_unit_tb;
    import ldfd_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TOTAL_ITEMS    = 900;

    // index 3 is not a register, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // how often a side pauses between transactions
    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_RARE} t_idle;

    // receiver state as the predictor tracks it
    typedef enum logic [1:0] {RX_HEADER, RX_PAYLOAD, RX_DROP} t_rx_phase;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } t_stream_item;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_MAGIC;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_cmd       = CMD_DATA;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [2:0]           o_status;
    logic [7:0]           o_payload_byte;
    logic                 o_last;

    // predictor copy of the registers and the receive state
    logic [31:0]      cfg_magic    = MAGIC_RST;
    logic [15:0]      cfg_version  = VERSION_RST;
    logic [31:0]      cfg_max_len  = MAX_PAYLOAD_DEF;
    t_rx_phase        rx_phase     = RX_HEADER;
    int unsigned      hdr_count    = 0;
    logic [7:0]       hdr_bytes [HDR_LEN];
    logic [LEN_W-1:0] payload_left = '0;

    t_stream_item stream_q [$];
    t_result      deframed_q [$];

    t_idle        send_mode      = IDLE_FULL;
    t_idle        recv_mode      = IDLE_FULL;
    int unsigned  send_gap       = 0;
    int unsigned  stall_left     = 0;
    int unsigned  hold_left      = 0;
    bit           hold_pending   = 1'b0;
    bit           in_take;
    bit           out_take;
    bit           in_fire        = 1'b0;
    bit           out_fire       = 1'b0;
    t_stream_item next_item;
    t_result      want;
    int unsigned  items_queued    = 0;
    int unsigned  items_accepted  = 0;
    int unsigned  results_checked = 0;
    int unsigned  cfg_writes      = 0;
    int unsigned  mismatches      = 0;
    int unsigned  quiet_cycles    = 0;
    int unsigned  status_seen [8] = '{default: 0};

    length_prefixed_frame_deframer_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predict the outcome of one accepted stream transaction
    task automatic deframe_step(input logic cmd, input logic [7:0] data);
        t_result     r;
        logic [31:0] len;
        bit          emit;
        r.status       = ST_DATA;
        r.payload_byte = 8'h00;
        r.last         = 1'b0;
        emit           = 1'b0;
        if (cmd == CMD_CLOSE) begin
            // a close while dropping stays silent, the error is already out
            if (rx_phase == RX_HEADER) begin
                emit = 1'b1;
                if (hdr_count == 0) begin
                    r.status = ST_END;
                end else begin
                    r.status = ST_TRUNC;
                end
            end else if (rx_phase == RX_PAYLOAD) begin
                emit     = 1'b1;
                r.status = ST_TRUNC;
            end
            rx_phase     = RX_HEADER;
            hdr_count    = 0;
            payload_left = '0;
        end else if (rx_phase == RX_HEADER) begin
            hdr_bytes[hdr_count] = data;
            hdr_count++;
            if (hdr_count == HDR_LEN) begin
                // checks in order: magic, version, flags, length
                hdr_count = 0;
                emit      = 1'b1;
                rx_phase  = RX_DROP;
                len = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
                if ({hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]} != cfg_magic) begin
                    r.status = ST_MAGIC;
                end else if ({hdr_bytes[4], hdr_bytes[5]} != cfg_version) begin
                    r.status = ST_VERSION;
                end else if ({hdr_bytes[6], hdr_bytes[7]} != 16'h0000) begin
                    r.status = ST_FLAGS;
                end else if (len > cfg_max_len) begin
                    r.status = ST_LONG;
                end else if (len == 0) begin
                    r.status = ST_EMPTY;
                    rx_phase = RX_HEADER;
                end else begin
                    emit         = 1'b0;
                    rx_phase     = RX_PAYLOAD;
                    payload_left = len[LEN_W-1:0];
                end
            end
        end else if (rx_phase == RX_PAYLOAD) begin
            emit           = 1'b1;
            r.payload_byte = data;
            r.last         = (payload_left <= 1);
            if (r.last) begin
                rx_phase     = RX_HEADER;
                payload_left = '0;
            end else begin
                payload_left--;
            end
        end
        if (emit) begin
            deframed_q.push_back(r);
        end
    endtask

    // register write, block idle; the predictor copy follows
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_MAGIC:   cfg_magic   = value;
            CFG_VERSION: cfg_version = value[15:0];
            CFG_MAX_LEN: begin
                // low length bits only, saturated at the cap
                cfg_max_len = {{(32-LEN_W){1'b0}}, value[LEN_W-1:0]};
                if (cfg_max_len > MAX_PAYLOAD_DEF) begin
                    cfg_max_len = MAX_PAYLOAD_DEF;
                end
            end
            default: ;
        endcase
    endtask

    function automatic int unsigned draw_gap(input t_idle mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(15);
            default:   return ($urandom_range(7) == 0) ? $urandom_range(15) : 0;
        endcase
    endfunction

    task automatic push_item(input logic cmd, input logic [7:0] data);
        t_stream_item it;
        it.cmd  = cmd;
        it.data = data;
        stream_q.push_back(it);
        items_queued++;
    endtask

    task automatic push_bytes(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            push_item(CMD_DATA, 8'($urandom));
        end
    endtask

    task automatic push_close();
        push_item(CMD_CLOSE, 8'($urandom));
    endtask

    // twelve header bytes, big-endian fields
    task automatic push_header(input logic [31:0] magic, input logic [15:0] ver,
                               input logic [15:0] flags, input logic [31:0] len);
        logic [95:0] h;
        h = {magic, ver, flags, len};
        for (int k = 11; k >= 0; k--) begin
            push_item(CMD_DATA, h[k*8 +: 8]);
        end
    endtask

    // payload length for a good frame: mostly short, sometimes the cap
    function automatic logic [31:0] pick_len();
        int unsigned r;
        int unsigned cap;
        r = $urandom_range(99);
        if (cfg_max_len == 0 || r < 10) begin
            return 32'd0;
        end
        if (r >= 95 && cfg_max_len <= 200) begin
            return cfg_max_len;
        end
        cap = (r < 75) ? 16 : ((r < 95) ? 64 : 200);
        if (cap > cfg_max_len) begin
            cap = cfg_max_len;
        end
        return $urandom_range(cap, 1);
    endfunction

    // one random stream piece, mostly well-formed frames
    task automatic push_piece();
        int unsigned kind;
        int unsigned n;
        logic [31:0] magic;
        logic [31:0] len;
        logic [15:0] ver;
        logic [15:0] flags;
        kind  = $urandom_range(99);
        magic = cfg_magic;
        ver   = cfg_version;
        flags = 16'h0000;
        len   = pick_len();
        if (kind < 55) begin
            push_header(magic, ver, flags, len);
            if (len != 0 && $urandom_range(15) == 0) begin
                // stream cut inside the payload
                push_bytes($urandom_range(len - 1));
                push_close();
            end else begin
                push_bytes(len);
            end
            return;
        end
        if (kind >= 87) begin
            if (kind < 93) begin
                push_close();
            end else if (kind < 97) begin
                push_bytes($urandom_range(11, 1));
                push_close();
            end else begin
                push_bytes($urandom_range(30, 1));
                push_close();
            end
            return;
        end
        // header errors; later fields random to exercise check priority
        if (kind < 63) begin
            magic = cfg_magic ^ (32'h1 << $urandom_range(31));
            if ($urandom_range(1)) ver = 16'($urandom);
            if ($urandom_range(1)) flags = 16'($urandom);
            if ($urandom_range(1)) len = $urandom;
        end else if (kind < 71) begin
            ver = cfg_version ^ (16'h1 << $urandom_range(15));
            if ($urandom_range(1)) flags = 16'($urandom);
            if ($urandom_range(1)) len = $urandom;
        end else if (kind < 79) begin
            if ($urandom_range(1)) begin
                flags = 16'h1 << $urandom_range(15);
            end else begin
                flags = 16'($urandom_range(16'hFFFF, 1));
            end
            if ($urandom_range(1)) len = $urandom;
        end else begin
            // just past the cap, or anywhere above it
            if ($urandom_range(1)) begin
                len = cfg_max_len + 1;
            end else begin
                len = $urandom_range(32'hFFFF_FFFF, cfg_max_len + 1);
            end
        end
        push_header(magic, ver, flags, len);
        // dropped bytes, not counted as stimulus
        n = $urandom_range(4);
        push_bytes(n);
        items_queued -= n;
        push_close();
    endtask

    // wait for all stimulus and results, then for the pipeline to settle
    task automatic drain();
        while (stream_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned n_items, input t_idle s_mode,
                             input t_idle r_mode);
        int unsigned stop_at;
        send_mode = s_mode;
        recv_mode = r_mode;
        stop_at   = items_queued + n_items;
        while (items_queued < stop_at) push_piece();
        drain();
    endtask

    // input side: note accepted transactions and predict their outcome
    always @(posedge i_clk) begin
        in_take = i_rst_n && i_in_valid && (o_in_stall === 1'b0);
        in_fire <= in_take;
        if (in_take) begin
            items_accepted++;
            deframe_step(i_cmd, i_data_byte);
        end
    end

    // stream driver: next transaction at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (send_gap != 0) begin
                i_in_valid <= 1'b0;
                send_gap--;
            end else if (stream_q.size() != 0) begin
                next_item = stream_q.pop_front();
                i_cmd       <= next_item.cmd;
                i_data_byte <= next_item.data;
                i_in_valid  <= 1'b1;
                send_gap    = draw_gap(send_mode);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall: per-result pauses plus one long hold on request
    always @(negedge i_clk) begin
        if (hold_pending) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (out_fire) begin
            stall_left = draw_gap(recv_mode);
        end
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result monitor: compare against the oldest prediction
    always @(posedge i_clk) begin
        out_take = i_rst_n && (o_out_valid === 1'b1) && !i_out_stall;
        out_fire <= out_take;
        if (out_take) begin
            results_checked++;
            if (!$isunknown(o_status)) begin
                status_seen[o_status]++;
            end
            if (deframed_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, status %0d byte %02h last %b",
                         $time, o_status, o_payload_byte, o_last);
            end else begin
                want = deframed_q.pop_front();
                if (o_status !== want.status) begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                end
                if (o_payload_byte !== want.payload_byte) begin
                    mismatches++;
                    $display("%0t: payload byte expected %02h actual %02h",
                             $time, want.payload_byte, o_payload_byte);
                end
                if (o_last !== want.last) begin
                    mismatches++;
                    $display("%0t: last expected %b actual %b", $time, want.last, o_last);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // clean end, cut header, two-byte frame with both byte extremes
        push_close();
        push_item(CMD_DATA, 8'h00);
        push_item(CMD_DATA, 8'hFF);
        push_close();
        push_header(cfg_magic, cfg_version, 16'h0000, 32'd2);
        push_item(CMD_DATA, 8'h00);
        push_item(CMD_DATA, 8'hFF);
        push_close();
        drain();

        // length at the default cap, just over it, and all ones
        push_header(cfg_magic, cfg_version, 16'h0000, MAX_PAYLOAD_DEF);
        push_bytes(3);
        push_close();
        push_header(cfg_magic, cfg_version, 16'h0000, MAX_PAYLOAD_DEF + 1);
        push_close();
        push_header(cfg_magic, cfg_version, 16'h0000, 32'hFFFF_FFFF);
        push_close();
        run_phase(120, IDLE_FULL, IDLE_FULL);

        // random magic and version, small cap, write to the unused index
        write_reg(CFG_MAGIC, $urandom);
        write_reg(CFG_VERSION, {16'($urandom), 16'($urandom)});
        write_reg(CFG_MAX_LEN, 32'd64);
        write_reg(CFG_UNUSED, $urandom);
        run_phase(200, IDLE_NONE, IDLE_NONE);

        // all-ones magic and version, zero cap
        write_reg(CFG_MAGIC, 32'hFFFF_FFFF);
        write_reg(CFG_VERSION, 32'h0000_FFFF);
        write_reg(CFG_MAX_LEN, 32'd0);
        run_phase(120, IDLE_RARE, IDLE_FULL);

        // zero magic and version, cap write with bits above the field; long hold
        write_reg(CFG_MAGIC, 32'h0000_0000);
        write_reg(CFG_VERSION, 32'h0000_0000);
        write_reg(CFG_MAX_LEN, 32'h0020_0005);
        @(posedge i_clk);
        hold_pending = 1'b1;
        run_phase(180, IDLE_NONE, IDLE_FULL);

        // oversize cap write saturates at the maximum
        write_reg(CFG_MAGIC, $urandom);
        write_reg(CFG_VERSION, $urandom_range(16'hFFFF));
        write_reg(CFG_MAX_LEN, 32'hFFFF_FFFF);
        if (items_queued < TOTAL_ITEMS) begin
            run_phase(TOTAL_ITEMS - items_queued, IDLE_FULL, IDLE_RARE);
        end

        $display("deframer run: %0d stream transactions, %0d results checked, %0d register writes",
                 items_accepted, results_checked, cfg_writes);
        $display("results per status data/empty/end/magic/version/flags/long/trunc: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
        if (mismatches == 0 && deframed_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
